### rtl/core/ric_pkg.sv
// shared types and constants for the refcounted inode cache
`timescale 1ns / 1ps
package ric_pkg;

	typedef enum logic [1:0] {
		CMD_GET  = 2'd0,
		CMD_PUT  = 2'd1,
		CMD_MARK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_MISS      = 3'd1,
		ST_FULL      = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_WRITEBACK = 3'd4,
		ST_MARKED    = 3'd5,
		ST_UNDERFLOW = 3'd6,
		ST_SATURATED = 3'd7
	} status_t;

	localparam logic REG_IPB   = 1'b0;
	localparam logic REG_START = 1'b1;

	localparam int unsigned IN_W  = 48;
	localparam int unsigned OUT_W = 72;

endpackage

### rtl/core/refcounted_inode_cache_top.sv
// refcounted inode cache: tag table in memory, scan sequencer, serial divider
// get: scans the entries, one read per cycle, stopping at a hit or after the last entry;
//   a miss or a write-back adds a 32-step restoring divide before the result
// put and mark: the slot is read in S_RD, modified and written back in S_OP, result in S_OUT
// throughput: one word at a time; the next word is taken once the result word is accepted
// reset: clears control and starts a clearing pass over the tag memory; no word taken during it
`timescale 1ns / 1ps
module refcounted_inode_cache_top
	import ric_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input word, tdata low to high: cmd, device_id, inode_number, slot_index
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	// result word, tdata low to high: status, slot, ref_after, disk_block, block_offset
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(ENTRIES);
	localparam int EW = 58; // valid, dirty, refs 16, device 8, inode 32

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_FREE, S_RD, S_OP, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	// config registers
	logic [8:0]  ipb_q;
	logic [31:0] start_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipb_q   <= 9'd8;
			start_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_IPB) ipb_q <= cfg_data[8:0];
			else start_q <= cfg_data;
		end
	end

	// tag memory: {valid, dirty, refs, device, inode}
	logic [EW-1:0] mem [ENTRIES];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// captured word
	logic [1:0]  cmd_q;
	logic [7:0]  dev_q;
	logic [31:0] ino_q;
	logic [5:0]  sidx_q;
	// scan bookkeeping
	logic [AW:0]   ptr_q;   // address issued
	logic          rdv_q;   // rd_q holds entry ptr_q-1
	logic [AW-1:0] radr_q;
	logic          free_found_q;
	logic [AW-1:0] free_q;
	// divider
	logic [31:0] dvd_q, quo_q;
	logic [8:0]  rem_q, dsr_q;
	logic [5:0]  dcnt_q;
	// result
	logic [2:0]  st_q;
	logic [5:0]  slot_q;
	logic [15:0] refs_q;
	logic        loc_q;

	wire rd_valid   = rd_q[EW-1];
	wire rd_dirty   = rd_q[EW-2];
	wire [15:0] rd_refs = rd_q[55:40];
	wire [7:0]  rd_dev  = rd_q[39:32];
	wire [31:0] rd_ino  = rd_q[31:0];
	wire hit = rd_valid && rd_dev == dev_q && rd_ino == ino_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);

	logic [9:0] rtrial;
	always_comb begin
		rtrial = {rem_q, dvd_q[31]} - {1'b0, dsr_q};
	end

	always_comb begin
		raddr = ptr_q[AW-1:0];
		// keep the hit entry on the read port so it is still there in S_OP
		if (state_q == S_SCAN && rdv_q && hit) raddr = radr_q;
		we = 1'b0;
		waddr = radr_q;
		wdata = rd_q;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = ptr_q[AW-1:0];
			wdata = '0;
		end else if (state_q == S_OP) begin
			if (cmd_q == CMD_GET) begin
				if (free_found_q && !(rdv_q && hit)) begin
					we = 1'b1;
					waddr = free_q;
					wdata = {1'b1, 1'b0, 16'd1, dev_q, ino_q};
				end else if (rdv_q && hit && rd_refs != 16'hFFFF) begin
					we = 1'b1;
					wdata = {rd_q[EW-1:EW-2], rd_refs + 16'd1, rd_q[39:0]};
				end
			end else if (sidx_q < ENTRIES) begin
				if (cmd_q == CMD_MARK) begin
					we = 1'b1;
					wdata = {rd_q[EW-1], 1'b1, rd_q[55:0]};
				end else if (rd_refs != 0) begin
					we = 1'b1;
					wdata = {rd_q[EW-1], rd_dirty && rd_refs != 16'd1,
						rd_refs - 16'd1, rd_q[39:0]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ptr_q <= '0;
			rdv_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == (AW+1)'(ENTRIES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (s_tvalid) begin
					cmd_q  <= s_tdata[1:0];
					dev_q  <= s_tdata[9:2];
					ino_q  <= s_tdata[41:10];
					sidx_q <= s_tdata[47:42];
					free_found_q <= 1'b0;
					rdv_q <= 1'b0;
					loc_q <= 1'b0;
					if (s_tdata[1:0] == CMD_GET) begin
						ptr_q <= '0;
						state_q <= S_SCAN;
					end else if (s_tdata[1:0] == CMD_NONE) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= (AW+1)'(s_tdata[47:42] % (1 << AW));
						state_q <= S_RD;
					end
				end
				S_SCAN: begin
					// check the entry read last cycle
					if (rdv_q && hit) begin
						state_q <= S_OP;
					end else begin
						if (rdv_q && rd_refs == 0 && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q <= radr_q;
						end
						if (ptr_q == (AW+1)'(ENTRIES)) begin
							rdv_q <= 1'b0;
							state_q <= S_OP;
						end else begin
							rdv_q <= 1'b1;
							radr_q <= ptr_q[AW-1:0];
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				S_RD: begin
					radr_q <= ptr_q[AW-1:0];
					state_q <= S_OP;
				end
				S_OP: begin
					state_q <= S_OUT;
					if (cmd_q == CMD_GET) begin
						if (rdv_q && hit) begin
							slot_q <= 6'(radr_q);
							st_q <= (rd_refs == 16'hFFFF) ? ST_SATURATED : ST_HIT;
							refs_q <= (rd_refs == 16'hFFFF) ? rd_refs : rd_refs + 16'd1;
						end else if (free_found_q) begin
							slot_q <= 6'(free_q);
							st_q <= ST_MISS;
							refs_q <= 16'd1;
							loc_q <= 1'b1;
							dvd_q <= ino_q - 32'd1;
							state_q <= S_DIV;
						end else begin
							slot_q <= '0;
							st_q <= ST_FULL;
							refs_q <= '0;
						end
					end else begin
						slot_q <= sidx_q;
						if (sidx_q >= ENTRIES) begin
							st_q <= ST_UNDERFLOW;
							refs_q <= '0;
						end else if (cmd_q == CMD_MARK) begin
							st_q <= ST_MARKED;
							refs_q <= rd_refs;
						end else if (rd_refs == 0) begin
							st_q <= ST_UNDERFLOW;
							refs_q <= '0;
						end else if (rd_refs == 16'd1 && rd_dirty) begin
							st_q <= ST_WRITEBACK;
							refs_q <= '0;
							loc_q <= 1'b1;
							dvd_q <= rd_ino - 32'd1;
							state_q <= S_DIV;
						end else begin
							st_q <= ST_RELEASED;
							refs_q <= rd_refs - 16'd1;
						end
					end
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= '0;
					dsr_q <= (ipb_q == 0) ? 9'd1 : (ipb_q > 9'd256) ? 9'd256 : ipb_q;
				end
				S_DIV: begin
					// one restoring step per cycle
					if (!rtrial[9]) begin
						rem_q <= rtrial[8:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[7:0], dvd_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					dvd_q <= {dvd_q[30:0], 1'b0};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'd31) state_q <= S_OUT;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	wire [32:0] blk = loc_q ? ({1'b0, start_q} + {1'b0, quo_q}) : 33'd0;
	wire [7:0]  off = loc_q ? rem_q[7:0] : 8'd0;
	assign m_tdata = {6'd0, off, blk, refs_q, slot_q, st_q};

`ifndef SYNTH
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input taken while result pending");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dcnt_q <= 6'd31) else $error("divider overran");
	a_loc_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && loc_q |-> (st_q == ST_MISS || st_q == ST_WRITEBACK))
		else $error("block reported for wrong status");
`endif

endmodule
